// File: rtl/sshash_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sshash_pkg;

    typedef logic [63:0] t_word;
    typedef logic [3:0]  t_step;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_mix_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_MIX1,
        ST_TAIL,
        ST_MIX2,
        ST_SUM,
        ST_DONE
    } t_state;

    localparam t_word HASH_MAGIC = 64'hde79d3747be356ce;
    localparam t_step MIX_LAST   = 4'd11;
    localparam logic [5:0] BLOCK_BYTES = 6'd32;
    localparam logic [5:0] HALF_BYTES  = 6'd16;

    // Rotation amount of each of the twelve mix steps.
    function automatic logic [5:0] rot_amount(input t_step step);
        logic [5:0] amt;
        begin
            unique case (step)
                4'd0:    amt = 6'd50;
                4'd1:    amt = 6'd52;
                4'd2:    amt = 6'd30;
                4'd3:    amt = 6'd41;
                4'd4:    amt = 6'd54;
                4'd5:    amt = 6'd48;
                4'd6:    amt = 6'd38;
                4'd7:    amt = 6'd37;
                4'd8:    amt = 6'd62;
                4'd9:    amt = 6'd34;
                4'd10:   amt = 6'd5;
                4'd11:   amt = 6'd36;
                default: amt = 6'd0;
            endcase
            return amt;
        end
    endfunction

    function automatic t_word rotl(input t_word x, input logic [5:0] r);
        logic [127:0] wide;
        begin
            wide = {x, x} << r;
            return wide[127:64];
        end
    endfunction

    // Keep the low k bytes of a word, k from 0 to 8.
    function automatic t_word keep_bytes(input t_word w, input logic [3:0] k);
        t_word mask;
        begin
            if (k >= 4'd8) begin
                mask = '1;
            end else begin
                mask = ~({64{1'b1}} << {k[2:0], 3'b000});
            end
            return w & mask;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/spooky_short_hash64_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming 64-bit short-message hash.
// Input channel (i_valid / o_ready): one 32-byte block per transfer as four
// little-endian words. i_message_length is sampled on the first block of a
// message only. i_last marks the final block, whose i_byte_count (0..32,
// larger values count as 32) gives its valid bytes; other blocks count as 32.
// Output channel (o_valid / i_ready): one o_hash per message, after its last
// block.
// Timing: a single mix unit does one rotate-add-xor step per cycle, and a
// mix takes twelve steps. A non-last block runs absorb and 12 mix steps,
// then the unit is ready again. A last block with 16 or more bytes runs two
// mixes (absorb, mix, tail, mix, sum, done); a shorter last block runs one
// (tail, mix, sum, done). From done, the hash moves to the output register
// and the next block is taken once that register is free. o_ready is low
// the whole time a block is worked on.
// The hash sits in an output register; the next block is taken while it
// waits. If the receiver stalls and a second hash is finished, the core
// holds it and stays not ready until the output register frees up.
// Reset: synchronous, active low; clears the sequencer, the open-message
// flag and the output valid.

module spooky_short_hash64_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  sshash_pkg::t_word   i_message_length,
    input  sshash_pkg::t_word   i_word0,
    input  sshash_pkg::t_word   i_word1,
    input  sshash_pkg::t_word   i_word2,
    input  sshash_pkg::t_word   i_word3,
    input  wire [5:0]           i_byte_count,
    input  wire                 i_last,
    output logic                o_valid,
    input  wire                 i_ready,
    output sshash_pkg::t_word   o_hash
);
    import sshash_pkg::*;

    logic  res_valid;
    logic  res_ready;
    t_word res_hash;
    logic  r_out_valid, n_out_valid;
    t_word r_hash, n_hash;

    sshash_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_message_length (i_message_length),
        .i_word0          (i_word0),
        .i_word1          (i_word1),
        .i_word2          (i_word2),
        .i_word3          (i_word3),
        .i_byte_count     (i_byte_count),
        .i_last           (i_last),
        .o_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .o_res_hash       (res_hash)
    );

    assign res_ready = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_hash      = r_hash;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
            n_hash      = res_hash;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
    end

    assign o_valid = r_out_valid;
    assign o_hash  = r_hash;

endmodule

`default_nettype wire

// File: rtl/sshash_mix_step.sv
`timescale 1ns / 1ps
`default_nettype none

module sshash_mix_step (
    input  sshash_pkg::t_step      i_step,
    input  sshash_pkg::t_mix_state i_st,
    output sshash_pkg::t_mix_state o_st
);
    import sshash_pkg::*;

    logic [5:0] rot;
    t_word      x;
    t_word      y;
    t_word      sum;

    assign rot = rot_amount(i_step);

    // Pick the rotated word and its addend; the roles cycle every four steps.
    always_comb begin
        unique case (i_step[1:0])
            2'd0: begin x = i_st.c; y = i_st.d; end
            2'd1: begin x = i_st.d; y = i_st.a; end
            2'd2: begin x = i_st.a; y = i_st.b; end
            2'd3: begin x = i_st.b; y = i_st.c; end
            default: begin x = i_st.c; y = i_st.d; end
        endcase
    end

    assign sum = rotl(x, rot) + y;

    always_comb begin
        o_st = i_st;
        unique case (i_step[1:0])
            2'd0: begin o_st.c = sum; o_st.a = i_st.a ^ sum; end
            2'd1: begin o_st.d = sum; o_st.b = i_st.b ^ sum; end
            2'd2: begin o_st.a = sum; o_st.c = i_st.c ^ sum; end
            2'd3: begin o_st.b = sum; o_st.d = i_st.d ^ sum; end
            default: o_st = i_st;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/sshash_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sshash_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  sshash_pkg::t_word   i_message_length,
    input  sshash_pkg::t_word   i_word0,
    input  sshash_pkg::t_word   i_word1,
    input  sshash_pkg::t_word   i_word2,
    input  sshash_pkg::t_word   i_word3,
    input  wire [5:0]           i_byte_count,
    input  wire                 i_last,
    output logic                o_res_valid,
    input  wire                 i_res_ready,
    output sshash_pkg::t_word   o_res_hash
);
    import sshash_pkg::*;

    t_state     r_state, n_state;
    t_step      r_step, n_step;
    t_mix_state r_st, n_st;
    t_mix_state mix_out;
    t_word      r_w0, n_w0, r_w1, n_w1, r_w2, n_w2, r_w3, n_w3;
    t_word      r_tail_c, n_tail_c, r_tail_d, n_tail_d;
    logic       r_full, n_full, r_last, n_last, r_in_msg, n_in_msg;

    // Decode of the incoming item
    logic       in_full;
    logic       in_upper;
    logic       in_pre;
    logic [3:0] tail_len;
    logic [3:0] lo_len;
    logic [3:0] hi_len;
    t_word      lo_word;
    t_word      hi_word;
    t_word      magic_add;
    t_word      seed;
    logic       step_last;

    sshash_mix_step u_step (
        .i_step (r_step),
        .i_st   (r_st),
        .o_st   (mix_out)
    );

    assign in_full   = !i_last || (i_byte_count >= BLOCK_BYTES);
    assign in_upper  = i_byte_count >= HALF_BYTES;
    assign in_pre    = in_full || in_upper;
    assign tail_len  = in_full  ? 4'd0
                     : in_upper ? 4'(i_byte_count - HALF_BYTES)
                     : i_byte_count[3:0];
    assign lo_word   = in_upper ? i_word2 : i_word0;
    assign hi_word   = in_upper ? i_word3 : i_word1;
    assign lo_len    = (tail_len > 4'd8) ? 4'd8 : tail_len;
    assign hi_len    = (tail_len > 4'd8) ? (tail_len - 4'd8) : 4'd0;
    assign magic_add = (tail_len < 4'd4) ? HASH_MAGIC : '0;
    assign seed      = i_message_length + HASH_MAGIC;
    assign step_last = (r_step == MIX_LAST);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_valid) n_state = in_pre ? ST_ABSORB : ST_TAIL;
            ST_ABSORB: n_state = ST_MIX1;
            ST_MIX1:   if (step_last) n_state = r_last ? ST_TAIL : ST_IDLE;
            ST_TAIL:   n_state = ST_MIX2;
            ST_MIX2:   if (step_last) n_state = ST_SUM;
            ST_SUM:    n_state = ST_DONE;
            ST_DONE:   if (i_res_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: o_ready     = 1'b1;
            ST_DONE: o_res_valid = 1'b1;
            default: begin
                o_ready     = 1'b0;
                o_res_valid = 1'b0;
            end
        endcase
    end

    assign o_res_hash = r_st.a + r_st.c;

    // Datapath next values
    always_comb begin
        n_st     = r_st;
        n_step   = r_step;
        n_w0     = r_w0;
        n_w1     = r_w1;
        n_w2     = r_w2;
        n_w3     = r_w3;
        n_tail_c = r_tail_c;
        n_tail_d = r_tail_d;
        n_full   = r_full;
        n_last   = r_last;
        n_in_msg = r_in_msg;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (!r_in_msg) begin
                        n_st = '{a: seed, b: seed, c: seed, d: seed};
                    end
                    n_in_msg = 1'b1;
                    n_w0     = i_word0;
                    n_w1     = i_word1;
                    n_w2     = i_word2;
                    n_w3     = i_word3;
                    n_full   = in_full;
                    n_last   = i_last;
                    n_tail_c = keep_bytes(lo_word, lo_len) + magic_add;
                    n_tail_d = keep_bytes(hi_word, hi_len) + magic_add;
                    n_step   = '0;
                end
            end
            ST_ABSORB: begin
                n_st.a = r_st.a + r_w0;
                n_st.b = r_st.b + r_w1;
                if (r_full) begin
                    n_st.c = r_st.c + r_w2;
                    n_st.d = r_st.d + r_w3;
                end
            end
            ST_MIX1, ST_MIX2: begin
                n_st   = mix_out;
                n_step = step_last ? '0 : r_step + 4'd1;
            end
            ST_TAIL: begin
                n_st.c = r_st.c + r_tail_c;
                n_st.d = r_st.d + r_tail_d;
            end
            ST_SUM: begin
                // fold into a and c; the done state adds those two
                n_st.a = r_st.a + r_st.b;
                n_st.c = r_st.c + r_st.d;
            end
            ST_DONE: begin
                if (i_res_ready) n_in_msg = 1'b0;
            end
            default: n_st = r_st;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_in_msg <= 1'b0;
            r_st     <= '0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_in_msg <= n_in_msg;
            r_st     <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w0     <= n_w0;
        r_w1     <= n_w1;
        r_w2     <= n_w2;
        r_w3     <= n_w3;
        r_tail_c <= n_tail_c;
        r_tail_d <= n_tail_d;
        r_full   <= n_full;
        r_last   <= n_last;
    end

endmodule

`default_nettype wire

// File: rtl/sshash_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sshash_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_valid,
    input wire                 o_ready,
    input wire                 o_valid,
    input wire                 i_ready,
    input sshash_pkg::t_word   o_hash
);
    import sshash_pkg::*;

    logic in_xfer;

    assign in_xfer = i_valid && o_ready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hash))
        else $error("result changed or dropped while stalled");

    // a block keeps the unit busy after its transfer, through the absorb or tail state and the first mix step
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_ready ##1 !o_ready)
        else $error("input ready again too soon after a transfer");

    // a new result is loaded only from the finishing state, never while idle
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared without a block in flight");

    // no result appears in the cycle after a transfer made while the output was empty
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !o_valid |=> !o_valid)
        else $error("result appeared one cycle after a transfer");

endmodule

bind spooky_short_hash64_unit sshash_checker u_sshash_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_hash  (o_hash)
);

`default_nettype wire
